/* hw/rtl/deadline_timer_queue_assert.svh */
// Assertion macros for the deadline timer queue checker.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DTQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtq assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define DTQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtq assertion failed");

`endif

/* hw/rtl/dtq_pkg.sv */
// Shared types, constants and helpers of the deadline timer queue.
package dtq_pkg;

	localparam int NUM_TIMERS = 64;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int TIME_W     = 48;
	localparam int PER_W      = 32;
	localparam int WIN_W      = 24;
	localparam int ID_W       = 6;

	localparam logic [WIN_W-1:0] WIN_RESET = 24'd3600000;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_RESET   = 3'd3;
	localparam logic [2:0] OP_POLL    = 3'd4;
	localparam logic [2:0] OP_QUERY   = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INACTIVE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic              active;
		logic              recurring;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] deadline;
		logic              mark;
	} slot_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [TIME_W-1:0] now_ms;
		logic [ID_W-1:0]   timer_id;
		logic [PER_W-1:0]  period_ms;
		logic              recurring;
		logic              restart_now;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [5:0]        slot_out;
		logic              expired;
		logic [TIME_W-1:0] wait_ms;
		logic              front_notify;
		logic              any_active;
		logic              last;
	} result_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [PER_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W + 1 - PER_W){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

/* hw/rtl/deadline_timer_queue.sv */
// Deadline timer queue: stream ports, ring of slot cells and sequencer.
// Each request walks the ring of NUM_TIMERS cells, one per cycle; the result is registered at the
// end of the pass, and no new request is taken until that result has been handed to the output.
// A reset that changes a slot adds a write pass before its result.
// Poll with n > 0 due: a select pass per due timer gives one result each, the last with m_tlast;
// a full output stalls the passes. arst_n clears slots, poll time, notify flag.
module deadline_timer_queue import dtq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // now_ms[47:0], timer_id[53:48], period_ms[85:54],
	                              // recurring[86], restart_now[87]
	input  logic [2:0]  s_tuser,  // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // status[1:0], slot_out[7:2], expired[8], wait_ms[56:9],
	                              // front_notify[57], any_active[58], zero[63:59]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	logic [WIN_W-1:0] win_q;
	item_t            item;
	result_t          res;
	slot_t            wb;
	slot_t            cq [NUM_TIMERS];
	logic             shift;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= WIN_RESET;
		else if (cfg_valid)
			win_q <= cfg_data;
	end

	assign item.op          = s_tuser;
	assign item.now_ms      = s_tdata[47:0];
	assign item.timer_id    = s_tdata[53:48];
	assign item.period_ms   = s_tdata[85:54];
	assign item.recurring   = s_tdata[86];
	assign item.restart_now = s_tdata[87];

	assign m_tdata = {5'b0, res.any_active, res.front_notify, res.wait_ms, res.expired,
		res.slot_out, res.status};
	assign m_tlast = res.last;

	// ring: each cell takes its upper neighbor, the top cell takes the write-back
	for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
		if (k == NUM_TIMERS - 1) begin : g_top
			dtq_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(wb), .q(cq[k]));
		end else begin : g_mid
			dtq_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(cq[k+1]),
				.q(cq[k]));
		end
	end

	dtq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.item     (item),
		.win      (win_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.result   (res),
		.head     (cq[0]),
		.wb       (wb),
		.shift    (shift)
	);

endmodule

/* hw/rtl/dtq_cell.sv */
// One timer slot of the ring; takes its neighbor's contents on every shift.
module dtq_cell import dtq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t d,
	output slot_t q
);

	logic              active_q, mark_q, recurring_q;
	logic [PER_W-1:0]  period_q;
	logic [TIME_W-1:0] deadline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mark_q   <= 1'b0;
		end else if (shift) begin
			active_q <= d.active;
			mark_q   <= d.mark;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			recurring_q <= d.recurring;
			period_q    <= d.period;
			deadline_q  <= d.deadline;
		end
	end

	assign q = {active_q, recurring_q, period_q, deadline_q, mark_q};

endmodule

/* hw/rtl/dtq_seq.sv */
// Sequencer: runs ring passes over the slot cells and builds the results.
module dtq_seq import dtq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_t            item,
	input  logic [WIN_W-1:0] win,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          result,
	input  slot_t            head,
	output slot_t            wb,
	output logic             shift
);

	typedef enum logic [2:0] {S_IDLE, S_PASS, S_DONE, S_CALC_A, S_CALC_B, S_EMIT} state_t;
	typedef enum logic [1:0] {PH_MAIN, PH_WRITE, PH_SELECT, PH_FLUSH} phase_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	state_t            state_q;
	phase_t            phase_q, next_phase_q;
	logic              then_pass_q;
	logic [IDX_W-1:0]  pidx_q, sel_q, upd_sel_q;
	logic [CNT_W-1:0]  ncnt_q;
	logic              found_q, blk_q, any_q, anyon_q, anyaf_q, upd_v_q;
	logic              fnotif_q, roll_q, ok_id_q;
	logic [TIME_W-1:0] best_q, newdl_q, cur_dl_q, prev_poll_q;
	logic [PER_W-1:0]  cur_per_q;
	item_t             it_q;
	result_t           res_q;
	logic              out_valid_q;
	result_t           result_q;

	logic hit, upd, take, cand, blk, due;
	logic [TIME_W-1:0] back_dist;

	result_t done_res;
	state_t  done_state;
	logic    done_then;
	logic    emit;

	assign in_ready  = (state_q == S_IDLE);
	assign shift     = (state_q == S_PASS);
	assign back_dist = prev_poll_q - item.now_ms;
	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		hit  = ok_id_q && (32'(it_q.timer_id) == 32'(pidx_q));
		upd  = upd_v_q && (pidx_q == upd_sel_q);
		wb   = head;
		take = 1'b0;
		cand = 1'b0;
		blk  = 1'b0;
		due  = 1'b0;
		case (it_q.op)
			OP_ADD: begin
				take = !head.active && !found_q;
				if (take) begin
					wb.active    = 1'b1;
					wb.recurring = it_q.recurring;
					wb.period    = it_q.period_ms;
					wb.deadline  = newdl_q;
				end
				blk = head.active && (head.deadline < newdl_q ||
					(head.deadline == newdl_q && !found_q));
			end
			OP_CANCEL: begin
				if (hit && head.active)
					wb.active = 1'b0;
			end
			OP_REFRESH: begin
				if (hit && head.active)
					wb.deadline = sat_add(it_q.now_ms, head.period);
			end
			OP_RESET: begin
				if (phase_q == PH_WRITE) begin
					if (hit) begin
						wb.period   = it_q.period_ms;
						wb.deadline = newdl_q;
					end
					blk = head.active && !hit && (head.deadline < newdl_q ||
						(head.deadline == newdl_q &&
						32'(pidx_q) < 32'(it_q.timer_id)));
				end
			end
			OP_QUERY: begin
				cand = head.active && (!found_q || head.deadline < best_q);
			end
			OP_POLL: begin
				if (phase_q == PH_MAIN) begin
					due     = head.active && (roll_q || head.deadline <= it_q.now_ms);
					wb.mark = due;
				end else begin
					if (upd) begin
						wb.mark = 1'b0;
						if (head.recurring)
							wb.deadline = sat_add(it_q.now_ms, head.period);
						else
							wb.active = 1'b0;
					end
					if (phase_q == PH_SELECT)
						cand = head.mark && !upd && (!found_q || head.deadline < best_q);
				end
			end
			default: ;
		endcase
	end

	// end-of-pass decision: result fields and where to go next
	always_comb begin
		done_res            = '0;
		done_res.any_active = any_q;
		done_res.last       = 1'b1;
		done_then           = 1'b0;
		done_state          = S_EMIT;
		case (it_q.op)
			OP_ADD: begin
				if (!found_q) begin
					done_res.status = ST_FULL;
				end else begin
					done_res.slot_out     = 6'(sel_q);
					done_res.front_notify = !blk_q && !fnotif_q;
				end
			end
			OP_CANCEL, OP_REFRESH: begin
				done_res.status = found_q ? ST_OK : ST_INACTIVE;
			end
			OP_RESET: begin
				if (phase_q == PH_WRITE)
					done_res.front_notify = !blk_q && !fnotif_q;
				else if (!ok_id_q)
					done_res.status = ST_INACTIVE;
				else if (it_q.period_ms == cur_per_q && !it_q.restart_now)
					done_res.status = ST_OK;
				else if (!found_q)
					done_res.status = ST_INACTIVE;
				else
					done_state = S_CALC_A;
			end
			OP_QUERY: begin
				done_res.any_active = found_q;
				if (!found_q)
					done_res.wait_ms = {TIME_W{1'b1}};
				else if (it_q.now_ms >= best_q)
					done_res.wait_ms = '0;
				else
					done_res.wait_ms = best_q - it_q.now_ms;
			end
			OP_POLL: begin
				case (phase_q)
					PH_MAIN: begin
						done_res.any_active = anyon_q;
						if (anyon_q && ncnt_q != '0)
							done_state = S_PASS;
					end
					PH_SELECT: begin
						done_res.slot_out   = 6'(sel_q);
						done_res.expired    = 1'b1;
						done_res.any_active = anyaf_q;
						done_res.last       = (ncnt_q == CNT_W'(1));
						done_then           = 1'b1;
					end
					default: done_state = S_IDLE;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fnotif_q    <= 1'b0;
			prev_poll_q <= '0;
			upd_v_q     <= 1'b0;
			phase_q     <= PH_MAIN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						it_q    <= item;
						ok_id_q <= (32'(item.timer_id) < 32'(NUM_TIMERS));
						newdl_q <= sat_add(item.now_ms, item.period_ms);
						roll_q  <= (item.now_ms < prev_poll_q) &&
							(back_dist > {{(TIME_W - WIN_W){1'b0}}, win});
						phase_q <= PH_MAIN;
						upd_v_q <= 1'b0;
						anyaf_q <= 1'b0;
						ncnt_q  <= '0;
						found_q <= 1'b0;
						blk_q   <= 1'b0;
						any_q   <= 1'b0;
						anyon_q <= 1'b0;
						pidx_q  <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					if (take || cand) begin
						found_q <= 1'b1;
						sel_q   <= pidx_q;
						best_q  <= head.deadline;
					end
					if (hit && phase_q == PH_MAIN && (it_q.op == OP_CANCEL ||
							it_q.op == OP_REFRESH || it_q.op == OP_RESET)) begin
						found_q   <= head.active;
						cur_per_q <= head.period;
						cur_dl_q  <= head.deadline;
					end
					blk_q   <= blk_q | blk;
					any_q   <= any_q | wb.active;
					anyon_q <= anyon_q | head.active;
					if (due)
						ncnt_q <= ncnt_q + 1'b1;
					if (phase_q == PH_MAIN && head.active && (!due || head.recurring))
						anyaf_q <= 1'b1;
					if (pidx_q == LAST_IDX) begin
						pidx_q  <= '0;
						state_q <= S_DONE;
					end else begin
						pidx_q <= pidx_q + 1'b1;
					end
				end
				S_DONE: begin
					res_q       <= done_res;
					then_pass_q <= done_then;
					state_q     <= done_state;
					case (it_q.op)
						OP_ADD: begin
							if (found_q && !blk_q)
								fnotif_q <= 1'b1;
						end
						OP_RESET: begin
							if (phase_q == PH_WRITE && !blk_q)
								fnotif_q <= 1'b1;
						end
						OP_QUERY: fnotif_q <= 1'b0;
						OP_POLL: begin
							case (phase_q)
								PH_MAIN: begin
									if (anyon_q)
										prev_poll_q <= it_q.now_ms;
									if (anyon_q && ncnt_q != '0) begin
										phase_q <= PH_SELECT;
										found_q <= 1'b0;
									end
								end
								PH_SELECT: begin
									ncnt_q       <= ncnt_q - 1'b1;
									upd_v_q      <= 1'b1;
									upd_sel_q    <= sel_q;
									next_phase_q <= (ncnt_q == CNT_W'(1)) ?
										PH_FLUSH : PH_SELECT;
								end
								default: upd_v_q <= 1'b0;
							endcase
						end
						default: ;
					endcase
				end
				S_CALC_A: begin
					if (it_q.restart_now)
						newdl_q <= it_q.now_ms;
					else if (cur_dl_q >= TIME_W'(cur_per_q))
						newdl_q <= cur_dl_q - TIME_W'(cur_per_q);
					else
						newdl_q <= '0;
					state_q <= S_CALC_B;
				end
				S_CALC_B: begin
					newdl_q <= sat_add(newdl_q, it_q.period_ms);
					phase_q <= PH_WRITE;
					blk_q   <= 1'b0;
					any_q   <= 1'b0;
					state_q <= S_PASS;
				end
				S_EMIT: begin
					if (emit) begin
						if (then_pass_q) begin
							phase_q <= next_phase_q;
							found_q <= 1'b0;
							state_q <= S_PASS;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/dtq_checker.sv */
// Port-level checker for the deadline timer queue, bound to the top level.
`include "deadline_timer_queue_assert.svh"

module dtq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast
);

	`DTQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`DTQ_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	`DTQ_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`DTQ_ASSERT_IMP(a_no_take_mid_poll, m_tvalid && !m_tlast, !s_tready)

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
